[rtl/core/sid_pkg.sv]
// Shared types and constants for the sorted identifier set insert block.
`timescale 1ns / 1ps
package sid_pkg;

	localparam int ID_W  = 16;
	localparam int POS_W = 9;
	localparam int ST_W  = 2;

	localparam logic [ST_W-1:0] ST_INSERTED = 2'd0;
	localparam logic [ST_W-1:0] ST_PRESENT  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic            load;
		logic            probe;
		logic            cmp;
		logic            shift_init;
		logic            shift;
		logic            insert;
		logic            emit;
		logic [ST_W-1:0] emit_code;
	} sid_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic search_done;
		logic hit;
		logic full;
		logic shift_done;
	} sid_stat_t;

endpackage

[rtl/core/sorted_id_set_insert.sv]
// Top level: sorted identifier set with binary search and insertion.
// Sequence: each probe issues a midpoint read and then compares the registered RAM data,
// repeated until the bounds meet; a decide state follows, and an insert then moves the
// entries above the position up one place each before the new key is written.
// The result strobe is registered from the emit command;
// one transaction is in flight at a time and the receiver cannot stall.
// Reset clears the fill count and control; table contents stay undefined until written.
`timescale 1ns / 1ps
module sorted_id_set_insert
	import sid_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [ID_W-1:0]  new_id,
	output logic             done,
	output logic [POS_W-1:0] position,
	output logic [ST_W-1:0]  status,
	output logic [POS_W-1:0] fill_count
);

	sid_cmd_t  cmd;
	sid_stat_t stat;

	sid_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	sid_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.new_id    (new_id),
		.done      (done),
		.position  (position),
		.status    (status),
		.fill_count(fill_count)
	);

endmodule

[rtl/core/sid_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module sid_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/sid_ctrl.sv]
// Controller state machine for search, shift and insert.
`timescale 1ns / 1ps
module sid_ctrl
	import sid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  sid_stat_t stat,
	output sid_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PROBE  = 3'd1;
	localparam logic [2:0] S_CMP    = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_SHIFT  = 3'd4;
	localparam logic [2:0] S_INSERT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	// Sequence one transaction
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_PROBE;
				end
			end
			S_PROBE: begin
				if (stat.search_done) begin
					state_d = S_DECIDE;
				end else begin
					cmd.probe = 1'b1;
					state_d   = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_PROBE;
			end
			S_DECIDE: begin
				if (stat.hit) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = ST_PRESENT;
					state_d       = S_IDLE;
				end else if (stat.full) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = ST_FULL;
					state_d       = S_IDLE;
				end else begin
					cmd.shift_init = 1'b1;
					state_d        = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					state_d = S_INSERT;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_INSERT: begin
				cmd.insert    = 1'b1;
				cmd.emit      = 1'b1;
				cmd.emit_code = ST_INSERTED;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/sid_dpath.sv]
// Datapath: search bounds, shift pointer, table memory and result registers.
`timescale 1ns / 1ps
module sid_dpath
	import sid_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sid_cmd_t         cmd,
	output sid_stat_t        stat,
	input  logic [ID_W-1:0]  new_id,
	output logic             done,
	output logic [POS_W-1:0] position,
	output logic [ST_W-1:0]  status,
	output logic [POS_W-1:0] fill_count
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [ID_W-1:0]  key_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [CW-1:0]    mid_q;
	logic             eq_q;
	logic [CW-1:0]    idx_q;
	logic             pend_q;
	logic [AW-1:0]    wr_addr_q;
	logic [CW-1:0]    mid;
	logic [CW-1:0]    idx_dec;
	logic [CW-1:0]    fill_next;
	logic [CW+POS_W-1:0] pos_ext;
	logic [CW+POS_W-1:0] fill_ext;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ID_W-1:0]  ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [ID_W-1:0]  ram_rdata;

	sid_ram #(
		.WIDTH(ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_dec = idx_q - CW'(1);

	// Status toward the controller
	assign stat.search_done = (lo_q >= hi_q);
	assign stat.hit         = eq_q;
	assign stat.full        = (count_q >= CW'(TABLE_DEPTH));
	assign stat.shift_done  = (idx_q == lo_q) && !pend_q;

	// Select the read address: probe midpoint or next entry to move up
	always_comb begin
		if (cmd.probe) begin
			ram_raddr = mid[AW-1:0];
		end else begin
			ram_raddr = idx_dec[AW-1:0];
		end
	end

	// Select the write: new key on insert, moved entry during shift
	always_comb begin
		if (cmd.insert) begin
			ram_we    = 1'b1;
			ram_waddr = lo_q[AW-1:0];
			ram_wdata = key_q;
		end else begin
			ram_we    = pend_q;
			ram_waddr = wr_addr_q;
			ram_wdata = ram_rdata;
		end
	end

	// Search bounds and shift pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= new_id;
			lo_q  <= '0;
			hi_q  <= count_q;
			eq_q  <= 1'b0;
		end
		if (cmd.probe) begin
			mid_q <= mid;
		end
		if (cmd.cmp) begin
			if (ram_rdata < key_q) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
				eq_q <= (ram_rdata == key_q);
			end
		end
		if (cmd.shift_init) begin
			idx_q <= count_q;
		end
		if (cmd.shift && (idx_q > lo_q)) begin
			idx_q     <= idx_dec;
			wr_addr_q <= idx_q[AW-1:0];
		end
	end

	// Track a read in flight that must land one place higher
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (cmd.shift_init) begin
			pend_q <= 1'b0;
		end else if (cmd.shift) begin
			pend_q <= (idx_q > lo_q);
		end
	end

	// Count valid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CW'(1);
		end
	end

	assign fill_next = cmd.insert ? (count_q + CW'(1)) : count_q;
	assign pos_ext   = {{POS_W{1'b0}}, lo_q};
	assign fill_ext  = {{POS_W{1'b0}}, fill_next};

	// Register the result with its strobe; the result is held until the next emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			position   <= pos_ext[POS_W-1:0];
			status     <= cmd.emit_code;
			fill_count <= fill_ext[POS_W-1:0];
		end
	end

endmodule

[dv/sorted_id_set_insert_test.sv]
// Self-checking testbench for the sorted identifier set insert block.
`timescale 1ns / 1ps
module sorted_id_set_insert_test;
	import sid_pkg::*;

	localparam int DEPTH        = 256;
	localparam int ITEM_TOTAL   = 1650;
	localparam int DRAIN_CYCLES = 400;
	localparam int IDLE_LIMIT   = 6000;

	typedef struct {
		logic [POS_W-1:0] position;
		logic [ST_W-1:0]  status;
		logic [POS_W-1:0] fill_count;
	} lookup_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [ID_W-1:0]  new_id = '0;
	logic             busy;
	logic             done;
	logic [POS_W-1:0] position;
	logic [ST_W-1:0]  status;
	logic [POS_W-1:0] fill_count;

	// Shadow copy of the table and its fill count
	logic [ID_W-1:0] shadow_ids [DEPTH];
	int              shadow_count = 0;

	// Identifiers waiting to be issued and results waiting to arrive
	logic [ID_W-1:0] pending_ids [$];
	lookup_result_t  expected_results [$];

	// Identifiers the stimulus expects to land in the table
	logic [ID_W-1:0] inserted_ids [$];
	bit              inserted_flag [int];

	int burst_left = 1;
	int gap_left = 0;
	int idle_cycles = 0;
	int error_count = 0;

	sorted_id_set_insert #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.new_id     (new_id),
		.done       (done),
		.position   (position),
		.status     (status),
		.fill_count (fill_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Search the shadow table, insert on a miss, and return the outcome
	function automatic lookup_result_t predict_insert(input logic [ID_W-1:0] key);
		int             lo;
		int             hi;
		int             mid;
		lookup_result_t res;
		lo = 0;
		hi = shadow_count;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (shadow_ids[mid] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		res.position = POS_W'(lo);
		if (lo < shadow_count && shadow_ids[lo] == key) begin
			res.status = ST_PRESENT;
		end else if (shadow_count >= DEPTH) begin
			res.status = ST_FULL;
		end else begin
			for (int i = shadow_count; i > lo; i--) begin
				shadow_ids[i] = shadow_ids[i - 1];
			end
			shadow_ids[lo] = key;
			shadow_count++;
			res.status = ST_INSERTED;
		end
		res.fill_count = POS_W'(shadow_count);
		return res;
	endfunction

	// Queue an identifier and track which ones will land in the table
	task automatic queue_id(input logic [ID_W-1:0] id);
		pending_ids.push_back(id);
		if (!inserted_flag.exists(id) && inserted_ids.size() < DEPTH) begin
			inserted_flag[id] = 1'b1;
			inserted_ids.push_back(id);
		end
	endtask

	function automatic logic [ID_W-1:0] pick_inserted();
		return inserted_ids[$urandom_range(0, inserted_ids.size() - 1)];
	endfunction

	function automatic void check_field(input string name, input int exp_val,
			input int got_val);
		if (exp_val != got_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				exp_val, got_val);
			error_count++;
		end
	endfunction

	// Driver: present identifiers in bursts with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start  <= 1'b0;
			new_id <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(predict_insert(new_id));
				void'(pending_ids.pop_front());
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					if ($urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(20, 300);
					end else begin
						gap_left = $urandom_range(0, 6);
					end
				end
			end
			if (gap_left > 0) begin
				gap_left--;
				if (start) begin
					start <= 1'b0;
				end
			end else if (pending_ids.size() > 0 && (!start || !busy)) begin
				start  <= 1'b1;
				new_id <= pending_ids[0];
			end else if (start && !busy) begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		lookup_result_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual pos %0d st %0d fill %0d",
					$time, position, status, fill_count);
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				check_field("position", int'(exp_res.position), int'(position));
				check_field("status", int'(exp_res.status), int'(status));
				check_field("fill_count", int'(exp_res.fill_count), int'(fill_count));
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] base;
		int              pick;

		// Directed: empty table, front and back inserts, hits, alternating bits
		queue_id(16'd1000);
		queue_id(16'd1000);
		queue_id(16'd500);
		queue_id(16'd2000);
		queue_id(16'd1500);
		queue_id(16'd999);
		queue_id(16'd1001);
		queue_id(16'd2);
		queue_id(16'd65533);
		queue_id(16'd65533);
		queue_id(16'd2);
		queue_id(16'h5555);
		queue_id(16'hAAAA);
		queue_id(16'h8000);
		queue_id(16'h7FFF);
		queue_id(16'h00FF);
		queue_id(16'hFF00);
		queue_id(16'd1500);
		queue_id(16'd500);

		// Random: keep the outer values free until the table fills, so that
		// a full table can reject at both ends
		while (pending_ids.size() < ITEM_TOTAL) begin
			pick = $urandom_range(0, 99);
			if (inserted_ids.size() < DEPTH) begin
				if (pick < 35) begin
					id = pick_inserted();
				end else if (pick < 50) begin
					base = pick_inserted();
					id = $urandom_range(0, 1) ? base + 16'd1 : base - 16'd1;
					if (id < 16'd2 || id > 16'd65533) begin
						id = base;
					end
				end else begin
					id = ID_W'($urandom_range(2, 65533));
				end
			end else begin
				if (pick < 40) begin
					id = pick_inserted();
				end else if (pick < 55) begin
					base = pick_inserted();
					id = $urandom_range(0, 1) ? base + 16'd1 : base - 16'd1;
				end else if (pick < 65) begin
					case ($urandom_range(0, 3))
						0: id = 16'd0;
						1: id = 16'd1;
						2: id = 16'd65534;
						default: id = 16'd65535;
					endcase
				end else begin
					id = ID_W'($urandom());
				end
			end
			queue_id(id);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all issued, all results back, then a quiet stretch
		while (pending_ids.size() > 0 || start) begin
			@(posedge clk);
		end
		while (expected_results.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
